>>> hdl/gfw_pkg.sv
// shared constants, types and the glyph font for the glyph framebuffer writer
// no dependencies

package gfw_pkg;

    localparam int SCREEN_WIDTH  = 128;
    localparam int SCREEN_HEIGHT = 128;
    localparam int PAGE_COUNT    = (SCREEN_HEIGHT + 7) / 8;
    localparam int STORE_BYTES   = SCREEN_WIDTH * PAGE_COUNT;
    localparam int ADDR_W        = $clog2(STORE_BYTES);
    localparam int FULL_PAGES    = SCREEN_HEIGHT / 8;
    localparam int PART_ROWS     = SCREEN_HEIGHT % 8;
    localparam logic [7:0] PART_MASK = 8'((1 << PART_ROWS) - 1);

    localparam int LETTER_COUNT = 26;
    localparam int GLYPH_COUNT  = 37;
    localparam int GLYPH_COLS   = 5;
    localparam int GLYPH_ROWS   = 8;
    localparam int SPACE_GLYPH  = 36;
    localparam int SLOT_W       = $clog2(GLYPH_COUNT);
    localparam int COL_W        = $clog2(GLYPH_COLS);
    localparam int ROM_DEPTH    = GLYPH_COUNT * GLYPH_COLS;
    localparam int ROM_W        = $clog2(ROM_DEPTH);

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // command codes on the input
    localparam logic [1:0] CMD_PIXEL = 2'd0;
    localparam logic [1:0] CMD_CHAR  = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;

    // decoded operation kinds
    localparam logic [1:0] OP_PIXEL = 2'd0;
    localparam logic [1:0] OP_GLYPH = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;
    localparam logic [1:0] OP_NONE  = 2'd3;

    typedef struct packed {
        logic [1:0]        kind;
        logic [8:0]        x_pos;
        logic [8:0]        y_pos;
        logic              pixel_on;
        logic [SLOT_W-1:0] slot;
        logic              found;
        logic              rd_ok;
        logic [10:0]       read_index;
    } t_op;

    localparam logic [7:0] GLYPH_ROM [ROM_DEPTH] = '{
        8'h7F, 8'h09, 8'h09, 8'h09, 8'h7F,  8'h7F, 8'h49, 8'h49, 8'h49, 8'h36,
        8'h3E, 8'h41, 8'h41, 8'h41, 8'h22,  8'h7F, 8'h41, 8'h41, 8'h41, 8'h3E,
        8'h7F, 8'h49, 8'h49, 8'h49, 8'h41,  8'h7F, 8'h09, 8'h09, 8'h09, 8'h01,
        8'h3E, 8'h41, 8'h49, 8'h49, 8'h3A,  8'h7F, 8'h08, 8'h08, 8'h08, 8'h7F,
        8'h00, 8'h41, 8'h7F, 8'h41, 8'h00,  8'h30, 8'h40, 8'h40, 8'h40, 8'h3F,
        8'h7F, 8'h08, 8'h14, 8'h22, 8'h41,  8'h7F, 8'h40, 8'h40, 8'h40, 8'h40,
        8'h7F, 8'h02, 8'h0C, 8'h02, 8'h7F,  8'h7F, 8'h02, 8'h04, 8'h08, 8'h7F,
        8'h3E, 8'h41, 8'h41, 8'h41, 8'h3E,  8'h7F, 8'h09, 8'h09, 8'h09, 8'h06,
        8'h3E, 8'h41, 8'h51, 8'h21, 8'h5E,  8'h7F, 8'h09, 8'h19, 8'h29, 8'h46,
        8'h26, 8'h49, 8'h49, 8'h49, 8'h32,  8'h01, 8'h01, 8'h7F, 8'h01, 8'h01,
        8'h3F, 8'h40, 8'h40, 8'h40, 8'h3F,  8'h07, 8'h18, 8'h60, 8'h18, 8'h07,
        8'h7F, 8'h20, 8'h18, 8'h20, 8'h7F,  8'h41, 8'h22, 8'h1C, 8'h22, 8'h41,
        8'h07, 8'h08, 8'h70, 8'h08, 8'h07,  8'h41, 8'h61, 8'h51, 8'h49, 8'h47,
        8'h3E, 8'h51, 8'h49, 8'h45, 8'h3E,  8'h00, 8'h42, 8'h7F, 8'h40, 8'h00,
        8'h42, 8'h61, 8'h51, 8'h49, 8'h46,  8'h21, 8'h41, 8'h45, 8'h4B, 8'h31,
        8'h18, 8'h14, 8'h12, 8'h7F, 8'h10,  8'h27, 8'h45, 8'h45, 8'h45, 8'h39,
        8'h3C, 8'h4A, 8'h49, 8'h49, 8'h30,  8'h01, 8'h71, 8'h09, 8'h05, 8'h03,
        8'h36, 8'h49, 8'h49, 8'h49, 8'h36,  8'h06, 8'h49, 8'h49, 8'h29, 8'h1E,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00
    };

    // rows of a page that lie on screen, one bit per row
    function automatic logic [7:0] page_rows(int page);
        logic [7:0] rows;
        if (page < 0) begin
            rows = 8'h00;
        end else if (page < FULL_PAGES) begin
            rows = 8'hFF;
        end else if (page == FULL_PAGES) begin
            rows = PART_MASK;
        end else begin
            rows = 8'h00;
        end
        return rows;
    endfunction

endpackage

>>> hdl/glyph_framebuffer_writer.sv
// top level of the glyph framebuffer writer: front end, queue and back end
// depends on gfw_pkg, gfw_front, gfw_queue, gfw_back
//
//   channel   valid     stall     payload
//   input     i_valid   o_stall   i_cmd i_x_pos i_y_pos i_pixel_on i_char_code i_read_index
//   output    o_valid   i_stall   o_read_data o_glyph_found
//
// each item gives one result; the back end sequencer works one item at a time
// pixel and draw-char items go in page steps, two per column (five columns for a
// glyph), each step on screen a read-modify-write: registered read, then write
// after reset a clearing pass zeroes the 2048-byte store, input stalled
// the two-entry queue keeps taking items while a result waits on output stall

module glyph_framebuffer_writer
    import gfw_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_cmd,
    input  logic [8:0]  i_x_pos,
    input  logic [8:0]  i_y_pos,
    input  logic        i_pixel_on,
    input  logic [7:0]  i_char_code,
    input  logic [10:0] i_read_index,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_read_data,
    output logic        o_glyph_found
);

    logic push, pop, q_full, q_valid, clearing;
    t_op  push_op, q_op;

    gfw_front u_front (
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_cmd        (i_cmd),
        .i_x_pos      (i_x_pos),
        .i_y_pos      (i_y_pos),
        .i_pixel_on   (i_pixel_on),
        .i_char_code  (i_char_code),
        .i_read_index (i_read_index),
        .i_queue_full (q_full),
        .i_clearing   (clearing),
        .o_push       (push),
        .o_op         (push_op)
    );

    gfw_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_op    (push_op),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_op    (q_op)
    );

    gfw_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (q_valid),
        .i_q_op        (q_op),
        .o_pop         (pop),
        .o_clearing    (clearing),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_read_data   (o_read_data),
        .o_glyph_found (o_glyph_found)
    );

endmodule

>>> hdl/gfw_front.sv
// front end: takes input items, decodes the command and the glyph slot
// depends on gfw_pkg

module gfw_front
    import gfw_pkg::*;
(
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_cmd,
    input  logic [8:0]  i_x_pos,
    input  logic [8:0]  i_y_pos,
    input  logic        i_pixel_on,
    input  logic [7:0]  i_char_code,
    input  logic [10:0] i_read_index,
    input  logic        i_queue_full,
    input  logic        i_clearing,
    output logic        o_push,
    output t_op         o_op
);

    logic              glyph_hit;
    logic [SLOT_W-1:0] slot;

    always_comb begin
        glyph_hit = 1'b1;
        slot      = '0;
        if (i_char_code >= 8'd65 && i_char_code <= 8'd90) begin
            slot = SLOT_W'(i_char_code - 8'd65);
        end else if (i_char_code >= 8'd97 && i_char_code <= 8'd122) begin
            slot = SLOT_W'(i_char_code - 8'd97);
        end else if (i_char_code >= 8'd48 && i_char_code <= 8'd57) begin
            slot = SLOT_W'(int'(i_char_code - 8'd48) + LETTER_COUNT);
        end else if (i_char_code == 8'd32) begin
            slot = SLOT_W'(SPACE_GLYPH);
        end else begin
            glyph_hit = 1'b0;
        end
    end

    always_comb begin
        o_op.x_pos      = i_x_pos;
        o_op.y_pos      = i_y_pos;
        o_op.pixel_on   = i_pixel_on;
        o_op.slot       = slot;
        o_op.found      = 1'b0;
        o_op.rd_ok      = (int'(i_read_index) < STORE_BYTES);
        o_op.read_index = i_read_index;
        unique case (i_cmd)
            CMD_PIXEL: o_op.kind = OP_PIXEL;
            CMD_CHAR: begin
                o_op.kind  = glyph_hit ? OP_GLYPH : OP_NONE;
                o_op.found = glyph_hit;
            end
            CMD_READ:  o_op.kind = OP_READ;
            default:   o_op.kind = OP_NONE;
        endcase
    end

    assign o_stall = i_queue_full | i_clearing;
    assign o_push  = i_valid & ~o_stall;

endmodule

>>> hdl/gfw_queue.sv
// short queue of decoded operations between front and back end
// depends on gfw_pkg

module gfw_queue
    import gfw_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_op  i_op,
    output logic o_full,
    input  logic i_pop,
    output logic o_valid,
    output t_op  o_op
);

    t_op               r_slot [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [QCNT_W-1:0] r_count, n_count;

    assign o_full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_op    = r_slot[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_op;
        end
    end

endmodule

>>> hdl/gfw_back.sv
// back end: framebuffer memory, clearing pass, read-modify-write sequencer
// and result register; depends on gfw_pkg

module gfw_back
    import gfw_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_q_valid,
    input  t_op        i_q_op,
    output logic       o_pop,
    output logic       o_clearing,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_read_data,
    output logic       o_glyph_found
);

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_PLAN  = 3'd2;
    localparam logic [2:0] ST_MOD   = 3'd3;
    localparam logic [2:0] ST_DONE  = 3'd4;

    logic [7:0] mem [STORE_BYTES];
    logic [7:0] r_mem_q;

    logic [2:0]       r_state, n_state;
    t_op              r_op, n_op;
    logic [COL_W-1:0] r_col, n_col;
    logic             r_half, n_half;
    logic [ADDR_W-1:0] r_clr_addr, n_clr_addr;
    logic [ADDR_W-1:0] r_addr, n_addr;
    logic [7:0]       r_mask, n_mask;
    logic [7:0]       r_wdata, n_wdata;
    logic             r_out_valid, n_out_valid;
    logic [7:0]       r_read_data, n_read_data;
    logic             r_glyph_found, n_glyph_found;

    logic              mem_we, mem_re;
    logic [ADDR_W-1:0] mem_waddr, mem_raddr;
    logic [7:0]        mem_wdata;

    // per-step geometry
    logic signed [9:0] col_x;
    logic signed [6:0] page;
    logic [2:0]        shift;
    logic [ROM_W-1:0]  rom_idx;
    logic [7:0]        col_bits, row_mask, step_data, step_mask;
    logic              col_ok, step_acc, step_last;
    logic [COL_W-1:0]  last_col;
    logic [ADDR_W-1:0] plan_addr;
    logic [2:0]        adv_state;
    logic [COL_W-1:0]  adv_col;
    logic              adv_half;
    logic              out_load;

    always_comb begin
        col_x    = $signed({r_op.x_pos[8], r_op.x_pos}) + $signed({7'd0, r_col});
        col_ok   = !col_x[9] && (int'(col_x) < SCREEN_WIDTH);
        page     = $signed({r_op.y_pos[8], r_op.y_pos[8:3]})
                 + $signed({6'd0, r_half});
        shift    = r_op.y_pos[2:0];
        rom_idx  = ROM_W'(int'(r_op.slot) * GLYPH_COLS + int'(r_col));
        if (r_op.kind == OP_GLYPH) begin
            col_bits = GLYPH_ROM[rom_idx];
            row_mask = 8'hFF;
            last_col = COL_W'(GLYPH_COLS - 1);
        end else begin
            col_bits = {7'd0, r_op.pixel_on};
            row_mask = 8'h01;
            last_col = '0;
        end
        // upper half goes to the page at y, lower rows spill into the next page
        if (r_half) begin
            step_data = col_bits >> (4'd8 - {1'b0, shift});
            step_mask = row_mask >> (4'd8 - {1'b0, shift});
        end else begin
            step_data = col_bits << shift;
            step_mask = row_mask << shift;
        end
        step_mask = step_mask & page_rows(int'(page));
        step_acc  = col_ok && (step_mask != 8'h00);
        plan_addr = ADDR_W'(int'(page) * SCREEN_WIDTH + int'(col_x));
        step_last = r_half && (r_col == last_col);
        adv_state = step_last ? ST_DONE : ST_PLAN;
        adv_half  = ~r_half;
        adv_col   = r_half ? r_col + 1'b1 : r_col;
    end

    assign out_load = (r_state == ST_DONE) && (!r_out_valid || !i_stall);

    always_comb begin
        n_state       = r_state;
        n_op          = r_op;
        n_col         = r_col;
        n_half        = r_half;
        n_clr_addr    = r_clr_addr;
        n_addr        = r_addr;
        n_mask        = r_mask;
        n_wdata       = r_wdata;
        n_read_data   = r_read_data;
        n_glyph_found = r_glyph_found;
        o_pop         = 1'b0;
        mem_we        = 1'b0;
        mem_re        = 1'b0;
        mem_waddr     = r_addr;
        mem_raddr     = plan_addr;
        mem_wdata     = (r_mem_q & ~r_mask) | (r_wdata & r_mask);

        unique case (r_state)
            ST_CLEAR: begin
                mem_we     = 1'b1;
                mem_waddr  = r_clr_addr;
                mem_wdata  = 8'h00;
                n_clr_addr = r_clr_addr + 1'b1;
                if (r_clr_addr == ADDR_W'(STORE_BYTES - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_q_valid) begin
                    o_pop   = 1'b1;
                    n_op    = i_q_op;
                    n_col   = '0;
                    n_half  = 1'b0;
                    n_state = (i_q_op.kind == OP_NONE) ? ST_DONE : ST_PLAN;
                end
            end
            ST_PLAN: begin
                if (r_op.kind == OP_READ) begin
                    mem_re    = 1'b1;
                    mem_raddr = ADDR_W'(r_op.read_index);
                    n_state   = ST_DONE;
                end else if (step_acc) begin
                    mem_re  = 1'b1;
                    n_addr  = plan_addr;
                    n_mask  = step_mask;
                    n_wdata = step_data;
                    n_state = ST_MOD;
                end else begin
                    n_state = adv_state;
                    n_col   = adv_col;
                    n_half  = adv_half;
                end
            end
            ST_MOD: begin
                mem_we  = 1'b1;
                n_state = adv_state;
                n_col   = adv_col;
                n_half  = adv_half;
            end
            ST_DONE: begin
                if (out_load) begin
                    n_read_data   = (r_op.kind == OP_READ && r_op.rd_ok) ? r_mem_q : 8'h00;
                    n_glyph_found = r_op.found;
                    n_state       = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        if (out_load) begin
            n_out_valid = 1'b1;
        end else if (!i_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_addr  <= '0;
            r_col       <= '0;
            r_half      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_col       <= n_col;
            r_half      <= n_half;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op          <= n_op;
        r_addr        <= n_addr;
        r_mask        <= n_mask;
        r_wdata       <= n_wdata;
        r_read_data   <= n_read_data;
        r_glyph_found <= n_glyph_found;
    end

    // framebuffer: one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_mem_q <= mem[mem_raddr];
        end
    end

    assign o_clearing    = (r_state == ST_CLEAR);
    assign o_valid       = r_out_valid;
    assign o_read_data   = r_read_data;
    assign o_glyph_found = r_glyph_found;

endmodule
